@@ design/adc_window_rms_meter_unit_defines.svh @@
// Assertion macros shared by the checker of the windowed RMS meter.
// Depends on signals named aclk and aresetn in the scope of each use.
`ifndef ADC_WINDOW_RMS_METER_UNIT_DEFINES_SVH
`define ADC_WINDOW_RMS_METER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ADCRMS_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ADCRMS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that is checked during reset as well.
`define ADCRMS_ASSERT_RESET(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/adcrms_pkg.sv @@
// Types and constants of the windowed RMS meter.
// No dependencies; used by every module of the block.
package adcrms_pkg;

    localparam int SUM_W      = 57;   // square sum accumulator
    localparam int LEN_W      = 11;   // window length and phase counter
    localparam int WARM_W     = 8;    // warm-up register
    localparam int MEAN_W     = 47;   // mean square result
    localparam int RMS_W      = 32;   // root result, 8 fraction bits
    localparam int FRAC_W     = 16;   // mean is scaled by 2^16 before the root
    localparam int CFG_ADDR_W = 8;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_ADDR_W-1:0] REG_WARMUP = 8'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_WINDOW = 8'd1;

    localparam logic [WARM_W-1:0] WARMUP_RESET = 8'd99;
    localparam logic [LEN_W-1:0]  WINDOW_RESET = 11'd1000;

    typedef struct packed {
        logic [7:0] sample_high;
        logic [7:0] sample_mid;
        logic [7:0] sample_low;
    } in_item_t;

    typedef struct packed {
        logic [MEAN_W-1:0] mean_square;
        logic [RMS_W-1:0]  rms_q8;
    } out_item_t;

    typedef struct packed {
        logic busy;
        logic done;
    } root_sts_t;

endpackage

@@ design/adcrms_root_unit.sv @@
// Bit-serial divider and digit-by-digit square root for the RMS meter.
// Depends on adcrms_pkg for widths, the result struct and the status struct.
module adcrms_root_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [adcrms_pkg::SUM_W-1:0]  sum_in,
    input  logic [adcrms_pkg::LEN_W-1:0]  len_in,
    output adcrms_pkg::root_sts_t         sts,
    output adcrms_pkg::out_item_t         result
);
    import adcrms_pkg::*;

    localparam int DIV_CNT_W = $clog2(SUM_W);
    localparam int SQ_X_W    = 2 * RMS_W;
    localparam int SQ_CNT_W  = $clog2(RMS_W);
    localparam int SQ_REM_W  = RMS_W + 2;
    localparam int SQ_TRY_W  = RMS_W + 4;

    typedef enum logic [1:0] {R_IDLE, R_DIV, R_SQRT} rstate_t;

    rstate_t               state_reg;
    logic [SUM_W-1:0]      num_reg;
    logic [LEN_W-1:0]      den_reg;
    logic [LEN_W-1:0]      div_rem_reg;
    logic [DIV_CNT_W-1:0]  div_cnt_reg;
    logic [SQ_X_W-1:0]     x_reg;
    logic [SQ_REM_W-1:0]   sq_rem_reg;
    logic [RMS_W-1:0]      root_reg;
    logic [SQ_CNT_W-1:0]   sq_cnt_reg;
    logic                  done_reg;
    out_item_t             result_reg;

    logic [LEN_W:0]        div_trial;
    logic [LEN_W:0]        div_diff;
    logic                  div_ge;
    logic [LEN_W-1:0]      div_rem_next;
    logic [SUM_W-1:0]      quot_next;

    logic [SQ_TRY_W-1:0]   sq_trial;
    logic [SQ_TRY_W-1:0]   sq_sub;
    logic [SQ_TRY_W-1:0]   sq_diff;
    logic                  sq_ge;
    logic [SQ_REM_W-1:0]   sq_rem_next;
    logic [RMS_W-1:0]      root_next;

    // One quotient bit per cycle, restoring form; quotient bits replace the
    // dividend bits as they shift out.
    always_comb begin
        div_trial    = {div_rem_reg, num_reg[SUM_W-1]};
        div_ge       = div_trial >= {1'b0, den_reg};
        div_diff     = div_trial - {1'b0, den_reg};
        div_rem_next = div_ge ? div_diff[LEN_W-1:0] : div_trial[LEN_W-1:0];
        quot_next    = {num_reg[SUM_W-2:0], div_ge};
    end

    // One root bit per cycle from two radicand bits.
    always_comb begin
        sq_trial    = {sq_rem_reg, x_reg[SQ_X_W-1 -: 2]};
        sq_sub      = {2'b00, root_reg, 2'b01};
        sq_ge       = sq_trial >= sq_sub;
        sq_diff     = sq_trial - sq_sub;
        sq_rem_next = sq_ge ? sq_diff[SQ_REM_W-1:0] : sq_trial[SQ_REM_W-1:0];
        root_next   = {root_reg[RMS_W-2:0], sq_ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= R_IDLE;
            done_reg  <= 1'b0;
        end else begin
            case (state_reg)
                R_IDLE: begin
                    done_reg <= 1'b0;
                    if (start) begin
                        num_reg     <= sum_in;
                        den_reg     <= len_in;
                        div_rem_reg <= '0;
                        div_cnt_reg <= '0;
                        state_reg   <= R_DIV;
                    end
                end
                R_DIV: begin
                    num_reg     <= quot_next;
                    div_rem_reg <= div_rem_next;
                    div_cnt_reg <= div_cnt_reg + 1'b1;
                    if (div_cnt_reg == DIV_CNT_W'(SUM_W - 1)) begin
                        result_reg.mean_square <= quot_next[MEAN_W-1:0];
                        x_reg      <= SQ_X_W'({quot_next[MEAN_W-1:0], {FRAC_W{1'b0}}});
                        sq_rem_reg <= '0;
                        root_reg   <= '0;
                        sq_cnt_reg <= '0;
                        state_reg  <= R_SQRT;
                    end
                end
                R_SQRT: begin
                    x_reg      <= {x_reg[SQ_X_W-3:0], 2'b00};
                    sq_rem_reg <= sq_rem_next;
                    root_reg   <= root_next;
                    sq_cnt_reg <= sq_cnt_reg + 1'b1;
                    if (sq_cnt_reg == SQ_CNT_W'(RMS_W - 1)) begin
                        result_reg.rms_q8 <= root_next;
                        done_reg          <= 1'b1;
                        state_reg         <= R_IDLE;
                    end
                end
                default: begin
                    state_reg <= R_IDLE;
                end
            endcase
        end
    end

    assign sts.busy = (state_reg != R_IDLE);
    assign sts.done = done_reg;
    assign result   = result_reg;

endmodule

@@ design/adc_window_rms_meter_unit.sv @@
// Top level of the windowed mean-square and RMS meter.
// Depends on adcrms_pkg and instantiates adcrms_root_unit.
//
//  Channel  | Ports                              | Moves
//  ---------+------------------------------------+-----------------------------------
//  input    | s_valid, s_ready, s_item           | one converter frame, three bytes
//  result   | m_valid, m_ready, m_item           | mean square and Q24.8 RMS value
//  config   | cfg_valid, cfg_ready, cfg_addr,    | register write, index 0 = warm-up,
//           | cfg_wdata                          | index 1 = window length
//
// A warm-up sample is only counted. A window sample is squared by the bit-serial
// shift-add squarer and added to the sum. The last sample of a window then runs the
// divide and root steps of the serial root unit before the result is handed off.
// Reset is synchronous and active low; it restores the register defaults and clears
// the phase state at once, with no clearing pass.
// A result waits in the output register while the next transaction is accepted; only
// a second finished window stalls behind a result that has not been taken.
module adc_window_rms_meter_unit #(
    parameter int WINDOW_MAX  = 1024,
    parameter int SAMPLE_BITS = 24
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  adcrms_pkg::in_item_t               s_item,
    output logic                               m_valid,
    input  logic                               m_ready,
    output adcrms_pkg::out_item_t              m_item,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [adcrms_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [adcrms_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import adcrms_pkg::*;

    localparam int PROD_W = 2 * SAMPLE_BITS;
    localparam int MCNT_W = $clog2(SAMPLE_BITS);
    localparam int RAW_W  = SAMPLE_BITS + 24;

    typedef enum logic [2:0] {S_IDLE, S_MUL, S_ACC, S_ROOT, S_EMIT} state_t;

    // Configuration registers.
    logic [WARM_W-1:0]       warmup_reg;
    logic [LEN_W-1:0]        window_reg;

    // Phase state and the serial squarer.
    state_t                  state_reg;
    logic                    in_window_reg;
    logic [LEN_W-1:0]        count_reg;
    logic [SUM_W-1:0]        sum_reg;
    logic [LEN_W-1:0]        len_reg;
    logic                    last_reg;
    logic [SAMPLE_BITS-1:0]  mcand_reg;
    logic [PROD_W-1:0]       acc_reg;
    logic [MCNT_W-1:0]       mcnt_reg;

    // Output register.
    logic                    m_valid_reg;
    out_item_t               m_item_reg;

    logic [RAW_W-1:0]        raw_ext;
    logic [SAMPLE_BITS-1:0]  raw;
    logic [SAMPLE_BITS-1:0]  mag;
    logic [LEN_W-1:0]        eff_len;
    logic                    warm_hold;
    logic [LEN_W-1:0]        cnt_base;
    logic [LEN_W:0]          cnt_inc;
    logic                    last_next;
    logic [SAMPLE_BITS:0]    mul_upper;
    logic [PROD_W-1:0]       acc_next;
    logic [PROD_W+SUM_W-1:0] sq_ext;
    logic [SUM_W-1:0]        sum_add;
    logic                    root_start;
    root_sts_t               root_sts;
    out_item_t               root_result;

    // The frame is taken as a SAMPLE_BITS-wide two's complement value; a width
    // beyond 24 bits leaves the sign bit clear, a narrower one drops high bits.
    always_comb begin
        raw_ext = {{SAMPLE_BITS{1'b0}}, s_item.sample_high, s_item.sample_mid,
                   s_item.sample_low};
        raw     = raw_ext[SAMPLE_BITS-1:0];
        mag     = raw[SAMPLE_BITS-1] ? (~raw + SAMPLE_BITS'(1)) : raw;
    end

    // A zero length counts as one sample, and a length beyond WINDOW_MAX saturates.
    always_comb begin
        if (window_reg == '0) begin
            eff_len = LEN_W'(1);
        end else if (32'(window_reg) > 32'(WINDOW_MAX)) begin
            eff_len = LEN_W'(WINDOW_MAX);
        end else begin
            eff_len = window_reg;
        end
    end

    // The first window sample restarts the count from zero. A count that already
    // reached a lowered length ends the window with this sample.
    always_comb begin
        warm_hold = !in_window_reg && (count_reg < LEN_W'(warmup_reg));
        cnt_base  = in_window_reg ? count_reg : '0;
        cnt_inc   = {1'b0, cnt_base} + (LEN_W + 1)'(1);
        last_next = cnt_inc >= {1'b0, eff_len};
    end

    // Shift-add squarer: one multiplier bit per cycle, the partial product shifts
    // right as the multiplier bits are used up.
    always_comb begin
        mul_upper = {1'b0, acc_reg[PROD_W-1:SAMPLE_BITS]}
                  + (acc_reg[0] ? {1'b0, mcand_reg} : '0);
        acc_next  = {mul_upper, acc_reg[SAMPLE_BITS-1:1]};
        sq_ext    = {{SUM_W{1'b0}}, acc_reg};
        sum_add   = sum_reg + sq_ext[SUM_W-1:0];
    end

    assign root_start = (state_reg == S_ACC) && last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            warmup_reg <= WARMUP_RESET;
            window_reg <= WINDOW_RESET;
        end else if (cfg_valid) begin
            case (cfg_addr)
                REG_WARMUP: warmup_reg <= cfg_wdata[WARM_W-1:0];
                REG_WINDOW: window_reg <= cfg_wdata[LEN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            in_window_reg <= 1'b0;
            count_reg     <= '0;
            sum_reg       <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            // In the emit state the valid flag is handled by that state alone.
            if (m_valid_reg && m_ready && (state_reg != S_EMIT)) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        if (warm_hold) begin
                            count_reg <= count_reg + 1'b1;
                        end else begin
                            if (!in_window_reg) begin
                                sum_reg <= '0;
                            end
                            in_window_reg <= 1'b1;
                            count_reg     <= cnt_inc[LEN_W-1:0];
                            len_reg       <= eff_len;
                            last_reg      <= last_next;
                            mcand_reg     <= mag;
                            acc_reg       <= {{SAMPLE_BITS{1'b0}}, mag};
                            mcnt_reg      <= '0;
                            state_reg     <= S_MUL;
                        end
                    end
                end
                S_MUL: begin
                    acc_reg  <= acc_next;
                    mcnt_reg <= mcnt_reg + 1'b1;
                    if (mcnt_reg == MCNT_W'(SAMPLE_BITS - 1)) begin
                        state_reg <= S_ACC;
                    end
                end
                S_ACC: begin
                    if (last_reg) begin
                        // The root unit captures the final sum; the phase restarts.
                        in_window_reg <= 1'b0;
                        count_reg     <= '0;
                        sum_reg       <= '0;
                        state_reg     <= S_ROOT;
                    end else begin
                        sum_reg   <= sum_add;
                        state_reg <= S_IDLE;
                    end
                end
                S_ROOT: begin
                    if (root_sts.done) begin
                        state_reg <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_item_reg  <= root_result;
                        m_valid_reg <= 1'b1;
                        state_reg   <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    adcrms_root_unit u_root (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (root_start),
        .sum_in  (sum_add),
        .len_in  (len_reg),
        .sts     (root_sts),
        .result  (root_result)
    );

    assign s_ready   = (state_reg == S_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_item    = m_item_reg;
    assign cfg_ready = 1'b1;

endmodule

@@ design/adcrms_checker.sv @@
// Port-level checker for the windowed RMS meter, bound to the top level.
// Depends on adcrms_pkg and the macros in adc_window_rms_meter_unit_defines.svh.
`include "adc_window_rms_meter_unit_defines.svh"

module adcrms_checker (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    input  logic                               s_ready,
    input  adcrms_pkg::in_item_t               s_item,
    input  logic                               m_valid,
    input  logic                               m_ready,
    input  adcrms_pkg::out_item_t              m_item,
    input  logic                               cfg_valid,
    input  logic                               cfg_ready,
    input  logic [adcrms_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [adcrms_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import adcrms_pkg::*;

    logic [2*RMS_W+1:0] rms_sq_lo;
    logic [2*RMS_W+1:0] rms_sq_hi;
    logic [2*RMS_W+1:0] scaled_mean;
    logic               input_seen;

    // The root must satisfy r*r <= mean*2^16 < (r+1)*(r+1).
    always_comb begin
        rms_sq_lo   = (2*RMS_W+2)'(m_item.rms_q8) * (2*RMS_W+2)'(m_item.rms_q8);
        rms_sq_hi   = ((2*RMS_W+2)'(m_item.rms_q8) + 1'b1)
                    * ((2*RMS_W+2)'(m_item.rms_q8) + 1'b1);
        scaled_mean = (2*RMS_W+2)'({m_item.mean_square, {FRAC_W{1'b0}}});
        input_seen  = s_valid || (|s_item) || cfg_valid || cfg_ready
                    || (|cfg_addr) || (|cfg_wdata);
    end

    `ADCRMS_ASSERT_NEXT(a_result_holds, m_valid && !m_ready,
        m_valid && $stable(m_item), "result changed or dropped while stalled")
    `ADCRMS_ASSERT_SAME(a_root_low, m_valid, rms_sq_lo <= scaled_mean,
        "rms_q8 squared exceeds the scaled mean square")
    `ADCRMS_ASSERT_SAME(a_root_high, m_valid, scaled_mean < rms_sq_hi,
        "rms_q8 is below the floor of the root")
    `ADCRMS_ASSERT_RESET(a_reset_idle, !aresetn || (!input_seen && !aresetn),
        !m_valid && s_ready, "block not idle after reset")

endmodule

bind adc_window_rms_meter_unit adcrms_checker u_adcrms_checker (.*);

@@ tb/sv/tb_adc_window_rms_meter_unit.sv @@
// Self-checking testbench for the windowed mean-square and RMS meter.
// Depends on adcrms_pkg and the RTL of adc_window_rms_meter_unit; a scoreboard class
// predicts every window result and checks each result transaction against it.
module tb_adc_window_rms_meter_unit;
    import adcrms_pkg::*;

    localparam int WINDOW_CAP   = 1024;   // saturation limit of the window length
    localparam int FRAME_TARGET = 1550;   // input transactions to send in all
    localparam int DRAIN_CYCLES = 160;    // covers the tail of a closing window
    localparam int STALL_LIMIT  = 5000;   // cycles without any transaction before timeout

    // The scoreboard keeps its own copy of the registers and of the phase state.
    // Each accepted frame is run through the same warm-up and window sequence as the
    // block, and a finished window leaves one expected reading in the queue.
    class mean_square_board;
        logic [WARM_W-1:0] warmup_len;
        logic [LEN_W-1:0]  window_len;
        bit                accumulating;
        logic [LEN_W-1:0]  phase_cnt;
        logic [SUM_W-1:0]  square_total;
        out_item_t         expected_readings[$];
        int                errors;
        int                checked;

        function new();
            warmup_len = WARMUP_RESET;
            window_len = WINDOW_RESET;
            errors     = 0;
            checked    = 0;
            restart();
        endfunction

        function void restart();
            accumulating = 1'b0;
            phase_cnt    = '0;
            square_total = '0;
        endfunction

        function void write_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
            if (addr == REG_WARMUP) begin
                warmup_len = data[WARM_W-1:0];
            end else if (addr == REG_WINDOW) begin
                window_len = data[LEN_W-1:0];
            end
        endfunction

        // Floored square root of mean * 2^16, found one result bit at a time.
        static function logic [RMS_W-1:0] root_q8(logic [MEAN_W-1:0] mean);
            logic [63:0]      scaled;
            logic [RMS_W-1:0] root;
            logic [RMS_W-1:0] trial;
            scaled = 64'(mean) << FRAC_W;
            root   = '0;
            for (int b = RMS_W - 1; b >= 0; b--) begin
                trial = root | (RMS_W'(1) << b);
                if (64'(trial) * 64'(trial) <= scaled) begin
                    root = trial;
                end
            end
            return root;
        endfunction

        function void take_sample(in_item_t frame);
            logic [23:0]      raw;
            logic [23:0]      mag;
            logic [LEN_W-1:0] len;
            out_item_t        reading;
            // A register lowered below the count ends the warm-up with this frame.
            if (!accumulating) begin
                if (phase_cnt < LEN_W'(warmup_len)) begin
                    phase_cnt++;
                    return;
                end
                accumulating = 1'b1;
                phase_cnt    = '0;
                square_total = '0;
            end
            raw = frame;
            // The most negative sample has magnitude 2^23, which still fits 24 bits.
            mag = raw[23] ? -raw : raw;
            square_total = square_total + SUM_W'(48'(mag) * 48'(mag));
            phase_cnt++;
            if (window_len == '0) begin
                len = LEN_W'(1);
            end else if (window_len > WINDOW_CAP) begin
                len = LEN_W'(WINDOW_CAP);
            end else begin
                len = window_len;
            end
            if (phase_cnt < len) begin
                return;
            end
            reading.mean_square = MEAN_W'(square_total / SUM_W'(len));
            reading.rms_q8      = root_q8(reading.mean_square);
            expected_readings.push_back(reading);
            restart();
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            if (expected_readings.size() == 0) begin
                $error("result with no window pending: mean_square %0d, rms_q8 %0d",
                       got.mean_square, got.rms_q8);
                errors++;
                return;
            end
            want = expected_readings.pop_front();
            checked++;
            if (got.mean_square !== want.mean_square) begin
                $error("mean_square mismatch: expected %0d, actual %0d",
                       want.mean_square, got.mean_square);
                errors++;
            end
            if (got.rms_q8 !== want.rms_q8) begin
                $error("rms_q8 mismatch: expected %0d, actual %0d", want.rms_q8, got.rms_q8);
                errors++;
            end
        endfunction

        function int pending();
            return expected_readings.size();
        endfunction
    endclass

    // Every input of the block starts at a known value; reset is held from time zero.
    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    in_item_t              s_item    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    out_item_t             m_item;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    mean_square_board board;
    int               frames_sent = 0;
    int               hold_left   = 0;
    int               idle_cycles = 0;
    bit               steady      = 1'b0;  // set for phases that run without any gaps

    // Full-scale positive and negative, zero, minus one and a few bit patterns.
    logic [23:0] corner_values[8] = '{24'h800000, 24'h7FFFFF, 24'h000000, 24'hFFFFFF,
                                      24'h000001, 24'h400000, 24'hFF00FF, 24'h00FF00};

    adc_window_rms_meter_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Gap lengths for both channels: mostly none or short, now and then a long one.
    function automatic int pick_gap();
        int r;
        if (steady) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end
        if (r < 94) begin
            return $urandom_range(1, 4);
        end
        return $urandom_range(12, 60);
    endfunction

    // Mostly full-range random samples, with corner values and small values mixed in.
    function automatic in_item_t random_frame();
        logic [23:0] v;
        case ($urandom_range(0, 9))
            0: begin
                v = corner_values[$urandom_range(0, 7)];
            end
            1: begin
                v = 24'($urandom_range(0, 255)) - 24'd128;
            end
            default: begin
                v = 24'($urandom);
            end
        endcase
        return in_item_t'(v);
    endfunction

    // Sends one frame. Valid is lowered only when a gap is wanted, so a frame that
    // follows directly keeps valid high across the acceptance edge.
    task automatic send_frame(input in_item_t frame);
        int gap;
        gap = pick_gap();
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= frame;
        do @(posedge aclk); while (!s_ready);
        board.take_sample(frame);
        frames_sent++;
    endtask

    task automatic cfg_put(input logic [CFG_ADDR_W-1:0] addr,
                           input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        do @(posedge aclk); while (!cfg_ready);
        board.write_reg(addr, data);
    endtask

    // Writes both registers back to back. Only called while the block is idle.
    task automatic configure(input logic [CFG_DATA_W-1:0] warm_data,
                             input logic [CFG_DATA_W-1:0] window_data);
        cfg_put(REG_WARMUP, warm_data);
        cfg_put(REG_WINDOW, window_data);
        cfg_valid <= 1'b0;
    endtask

    // Waits until every predicted result has been taken, then lets the block finish
    // a frame that produces no result before anything else is written.
    task automatic settle();
        s_valid <= 1'b0;
        while (board.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // The result side stalls on its own schedule, independent of the input side.
    always @(posedge aclk) begin
        if (hold_left != 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else begin
            m_ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) begin
                hold_left <= pick_gap();
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            board.check_result(m_item);
        end
    end

    // The run times out when no transaction of any kind completes for too long.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles == STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        int n;
        board = new();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Two frames under the reset registers are swallowed by the 99-frame warm-up.
        repeat (2) send_frame(random_frame());
        settle();

        // Zero warm-up written while the warm-up count is already past it: the next
        // frame opens the window. A one-frame window then reports every frame.
        configure(16'd0, 16'd1);
        foreach (corner_values[i]) begin
            send_frame(in_item_t'(corner_values[i]));
        end
        settle();

        // A zero window length behaves as a window of one frame.
        configure(16'd0, 16'd0);
        send_frame(in_item_t'(24'h800000));
        send_frame(in_item_t'(24'h123456));
        settle();

        // Window shortened to the count already reached: the next frame closes it.
        configure(16'd2, 16'd4);
        repeat (4) send_frame(random_frame());
        settle();
        configure(16'd2, 16'd2);
        send_frame(random_frame());
        settle();

        // Warm-up shortened below the count already reached: the next frame opens
        // the window and counts as its first frame.
        configure(16'd200, 16'd3);
        repeat (3) send_frame(random_frame());
        settle();
        configure(16'd1, 16'd3);
        repeat (3) send_frame(random_frame());
        settle();

        // Longest warm-up and a length at or above the cap, which saturates to 1024 frames.
        // Upper data bits beyond each register's width are set at random.
        configure({8'($urandom), 8'd255},
                  16'(WINDOW_CAP) | (16'($urandom_range(0, 31)) << 11)
                  | 16'($urandom_range(0, WINDOW_CAP - 1)));
        repeat (255 + WINDOW_CAP) send_frame(random_frame());
        settle();

        // Short random phases. Some keep the previous registers, and most end part of
        // the way through a warm-up or a window, so the next phase starts mid-count.
        while (frames_sent < FRAME_TARGET) begin
            steady = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 4) != 0) begin
                configure({8'($urandom), 8'($urandom_range(0, 5))},
                          {5'($urandom), 11'($urandom_range(0, 9))});
            end
            n = $urandom_range(1, 30);
            repeat (n) send_frame(random_frame());
            settle();
        end

        if (board.errors == 0 && board.pending() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
